>>> rtl/core/ist_pkg.sv
// shared types, constants and codes for the interval set table
package ist_pkg;

    localparam int MaxEntries = 16;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = $clog2(MaxEntries + 1);
    localparam int TmpW       = $clog2(MaxEntries + 3);

    // signed 64-bit limits for saturation
    localparam logic signed [63:0] SMax = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SMin = {1'b1, {63{1'b0}}};

    typedef enum logic [2:0] {
        KIND_UNION     = 3'd0,
        KIND_SUBTRACT  = 3'd1,
        KIND_INTERSECT = 3'd2,
        KIND_SHIFT     = 3'd3,
        KIND_POINT     = 3'd4
    } kind_code_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_ORDER = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [63:0] range_start;
        logic signed [63:0] range_end;
        logic signed [63:0] shift_amount;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               point_covered;
        logic [4:0]         entries_used;
        logic [63:0]        total_covered;
        logic signed [63:0] span_start;
        logic signed [63:0] span_end;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic latch;    // capture command beat
        logic rd_req;   // issue table read at scan index
        logic proc;     // process the read entry
        logic tail;     // emit pending merged range at end of walk
        logic commit;   // copy scratch to table, one entry
        logic sum;      // accumulate stats for one entry
        logic clr_sum;  // rewind index and clear stats accumulators
        logic finish;   // drive result
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic commit_done;
        logic sum_done;
        logic ok;
        logic skip;
    } sts_t;

endpackage

>>> rtl/core/ist_ctrl.sv
// controller state machine for the interval set table
module ist_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ist_pkg::sts_t   sts,
    output ist_pkg::ctl_t   ctl
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b0_0000_0001,
        S_CHECK  = 9'b0_0000_0010,
        S_READ   = 9'b0_0000_0100,
        S_PROC   = 9'b0_0000_1000,
        S_TAIL   = 9'b0_0001_0000,
        S_COMMIT = 9'b0_0010_0000,
        S_REWIND = 9'b0_0100_0000,
        S_SUM    = 9'b0_1000_0000,
        S_DONE   = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.skip)
                    state_next = S_REWIND;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (sts.walk_done)
                    state_next = S_TAIL;
                else
                begin
                    ctl.rd_req = 1'b1;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                ctl.proc   = 1'b1;
                state_next = S_READ;
            end
            S_TAIL:
            begin
                ctl.tail   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!sts.ok || sts.commit_done)
                    state_next = S_REWIND;
                else
                    ctl.commit = 1'b1;
            end
            S_REWIND:
            begin
                ctl.clr_sum = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                if (sts.sum_done)
                    state_next = S_DONE;
                else
                    ctl.sum = 1'b1;
            end
            S_DONE:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/core/ist_datapath.sv
// table storage, scratch table and per-entry arithmetic
module ist_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  ist_pkg::cmd_t   cmd,
    input  ist_pkg::ctl_t   ctl,
    output ist_pkg::sts_t   sts,
    output logic            done,
    output ist_pkg::rsp_t   result
);

    // table and scratch memories
    logic signed [63:0] tab_s [ist_pkg::MaxEntries];
    logic signed [63:0] tab_e [ist_pkg::MaxEntries];
    logic signed [63:0] tmp_s [ist_pkg::MaxEntries];
    logic signed [63:0] tmp_e [ist_pkg::MaxEntries];

    ist_pkg::cmd_t              cmd_reg;
    logic [ist_pkg::CntW-1:0]   count_reg;
    logic [ist_pkg::CntW-1:0]   idx_reg, idx_next;
    logic [ist_pkg::TmpW-1:0]   n_reg, n_next;
    logic                       placed_reg, placed_next;
    logic                       cov_reg;
    logic signed [63:0]         ms_reg, ms_next, me_reg, me_next;
    logic signed [63:0]         rd_s_reg, rd_e_reg;
    logic signed [63:0]         cp_s_reg, cp_e_reg;
    logic [ist_pkg::IdxW-1:0]   cp_idx_reg;
    logic                       cp_vld_reg;
    logic                       sum_vld_reg;
    logic [63:0]                tot_reg;
    logic signed [63:0]         first_reg, last_reg;
    logic [1:0]                 status_reg;
    logic                       done_reg;

    // write queue from processing into scratch: up to two entries
    logic                       w0_en, w1_en;
    logic signed [63:0]         w0_s, w0_e, w1_s, w1_e;
    logic [ist_pkg::TmpW-1:0]   n_plus1;
    logic [ist_pkg::IdxW-1:0]   w0_idx, w1_idx;

    // saturating shift of the read entry
    logic [64:0]                amt_wide, sh_s_wide, sh_e_wide;
    logic signed [63:0]         sh_s, sh_e;
    logic                       order_bad, empty_rng;
    logic                       is_union, is_sub, is_int, is_shift, is_point;

    // stats
    logic [63:0]                len;
    logic [64:0]                tot_wide;

    // command decode
    assign is_union  = cmd_reg.kind == ist_pkg::KIND_UNION;
    assign is_sub    = cmd_reg.kind == ist_pkg::KIND_SUBTRACT;
    assign is_int    = cmd_reg.kind == ist_pkg::KIND_INTERSECT;
    assign is_shift  = cmd_reg.kind == ist_pkg::KIND_SHIFT;
    assign is_point  = cmd_reg.kind == ist_pkg::KIND_POINT;
    assign order_bad = (is_union || is_sub || is_int)
                     && (cmd_reg.range_end < cmd_reg.range_start);
    assign empty_rng = cmd_reg.range_start == cmd_reg.range_end;

    // sign-extended sums, clamped where the top two bits disagree
    assign amt_wide  = {cmd_reg.shift_amount[63], cmd_reg.shift_amount};
    assign sh_s_wide = {rd_s_reg[63], rd_s_reg} + amt_wide;
    assign sh_e_wide = {rd_e_reg[63], rd_e_reg} + amt_wide;
    assign sh_s = (sh_s_wide[64:63] == 2'b01) ? ist_pkg::SMax :
                  (sh_s_wide[64:63] == 2'b10) ? ist_pkg::SMin : sh_s_wide[63:0];
    assign sh_e = (sh_e_wide[64:63] == 2'b01) ? ist_pkg::SMax :
                  (sh_e_wide[64:63] == 2'b10) ? ist_pkg::SMin : sh_e_wide[63:0];

    // status toward controller
    always_comb
    begin
        sts.skip        = order_bad || ((is_union || is_sub) && empty_rng)
                        || !(is_union || is_sub || is_int || is_shift);
        sts.walk_done   = idx_reg == count_reg;
        sts.ok          = n_reg <= ist_pkg::TmpW'(ist_pkg::MaxEntries);
        sts.commit_done = ist_pkg::TmpW'(idx_reg) == n_reg;
        sts.sum_done    = idx_reg == count_reg;
    end

    // per-entry processing
    always_comb
    begin
        w0_en = 1'b0;
        w1_en = 1'b0;
        w0_s  = rd_s_reg;
        w0_e  = rd_e_reg;
        w1_s  = rd_s_reg;
        w1_e  = rd_e_reg;
        placed_next = placed_reg;
        ms_next = ms_reg;
        me_next = me_reg;
        if (ctl.proc)
        begin
            if (is_union)
            begin
                if (rd_e_reg < cmd_reg.range_start)
                    w0_en = 1'b1;
                else if (rd_s_reg > cmd_reg.range_end)
                begin
                    if (!placed_reg)
                    begin
                        w0_en = 1'b1;
                        w0_s  = ms_reg;
                        w0_e  = me_reg;
                        w1_en = 1'b1;
                        placed_next = 1'b1;
                    end
                    else
                        w0_en = 1'b1;
                end
                else
                begin
                    if (rd_s_reg < ms_reg) ms_next = rd_s_reg;
                    if (rd_e_reg > me_reg) me_next = rd_e_reg;
                end
            end
            else if (is_sub)
            begin
                if (rd_e_reg <= cmd_reg.range_start || rd_s_reg >= cmd_reg.range_end)
                    w0_en = 1'b1;
                else
                begin
                    w0_en = rd_s_reg < cmd_reg.range_start;
                    w0_e  = cmd_reg.range_start;
                    w1_en = rd_e_reg > cmd_reg.range_end;
                    w1_s  = cmd_reg.range_end;
                end
            end
            else if (is_int)
            begin
                w0_s = (rd_s_reg < cmd_reg.range_start) ? cmd_reg.range_start : rd_s_reg;
                w0_e = (rd_e_reg > cmd_reg.range_end) ? cmd_reg.range_end : rd_e_reg;
                w0_en = w0_s < w0_e;
            end
            else
            begin
                w0_s  = sh_s;
                w0_e  = sh_e;
                w0_en = sh_s != sh_e;
            end
        end
        else if (ctl.tail && is_union && !placed_reg)
        begin
            w0_en = 1'b1;
            w0_s  = ms_reg;
            w0_e  = me_reg;
        end
        // compact the pair so w0 is the first written
        if (!w0_en && w1_en)
        begin
            w0_en = 1'b1;
            w0_s  = w1_s;
            w0_e  = w1_e;
            w1_en = 1'b0;
        end
        // new command starts an empty scratch and a fresh merge range
        if (ctl.latch)
        begin
            n_next      = '0;
            placed_next = 1'b0;
            ms_next     = cmd.range_start;
            me_next     = cmd.range_end;
        end
        else
            n_next = n_reg + ist_pkg::TmpW'(w0_en) + ist_pkg::TmpW'(w1_en);
    end

    assign n_plus1 = n_reg + ist_pkg::TmpW'(1);
    assign w0_idx  = n_reg[ist_pkg::IdxW-1:0];
    assign w1_idx  = n_plus1[ist_pkg::IdxW-1:0];

    // scratch writes, dropped past capacity (the count still records overflow)
    always_ff @(posedge clk)
    begin
        if (w0_en && n_reg < ist_pkg::TmpW'(ist_pkg::MaxEntries))
        begin
            tmp_s[w0_idx] <= w0_s;
            tmp_e[w0_idx] <= w0_e;
        end
        if (w1_en && n_plus1 < ist_pkg::TmpW'(ist_pkg::MaxEntries))
        begin
            tmp_s[w1_idx] <= w1_s;
            tmp_e[w1_idx] <= w1_e;
        end
    end

    // table reads for walk and sum; commit writes the cycle after its read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_req || ctl.sum)
        begin
            rd_s_reg <= tab_s[idx_reg[ist_pkg::IdxW-1:0]];
            rd_e_reg <= tab_e[idx_reg[ist_pkg::IdxW-1:0]];
        end
        if (ctl.commit)
        begin
            cp_s_reg   <= tmp_s[idx_reg[ist_pkg::IdxW-1:0]];
            cp_e_reg   <= tmp_e[idx_reg[ist_pkg::IdxW-1:0]];
            cp_idx_reg <= idx_reg[ist_pkg::IdxW-1:0];
        end
        if (cp_vld_reg)
        begin
            tab_s[cp_idx_reg] <= cp_s_reg;
            tab_e[cp_idx_reg] <= cp_e_reg;
        end
    end

    // scan index: rewound for walk, copy and sum
    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.latch || ctl.tail || ctl.clr_sum)
            idx_next = '0;
        else if (ctl.rd_req || ctl.commit || ctl.sum)
            idx_next = idx_reg + ist_pkg::CntW'(1);
    end

    assign len      = 64'(rd_e_reg) - 64'(rd_s_reg);
    assign tot_wide = {1'b0, tot_reg} + {1'b0, len};

    // control and stats registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
            placed_reg  <= 1'b0;
            ms_reg      <= '0;
            me_reg      <= '0;
            cov_reg     <= 1'b0;
            cp_vld_reg  <= 1'b0;
            sum_vld_reg <= 1'b0;
            status_reg  <= ist_pkg::STATUS_DONE;
            done_reg    <= 1'b0;
            tot_reg     <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            placed_reg  <= placed_next;
            ms_reg      <= ms_next;
            me_reg      <= me_next;
            cp_vld_reg  <= ctl.commit;
            sum_vld_reg <= ctl.sum;
            done_reg    <= ctl.finish;
            if (ctl.latch)
                cmd_reg <= cmd;
            // status: order check at accept, capacity check at end of walk
            if (ctl.latch)
                status_reg <= (cmd.kind <= ist_pkg::KIND_INTERSECT
                               && cmd.range_end < cmd.range_start)
                              ? ist_pkg::STATUS_ORDER : ist_pkg::STATUS_DONE;
            else if (ctl.tail && n_next > ist_pkg::TmpW'(ist_pkg::MaxEntries))
                status_reg <= ist_pkg::STATUS_FULL;
            if (ctl.tail && n_next <= ist_pkg::TmpW'(ist_pkg::MaxEntries))
                count_reg <= ist_pkg::CntW'(n_next);
            // point test during the sum pass
            if (ctl.latch)
                cov_reg <= 1'b0;
            else if (sum_vld_reg && is_point
                     && rd_s_reg <= cmd_reg.range_start && cmd_reg.range_start < rd_e_reg)
                cov_reg <= 1'b1;
            // coverage and span
            if (ctl.clr_sum)
            begin
                tot_reg   <= '0;
                first_reg <= '0;
                last_reg  <= '0;
            end
            else if (sum_vld_reg)
            begin
                tot_reg <= tot_wide[64] ? '1 : tot_wide[63:0];
                if (idx_reg == ist_pkg::CntW'(1))
                    first_reg <= rd_s_reg;
                last_reg <= rd_e_reg;
            end
        end
    end

    assign done = done_reg;
    always_comb
    begin
        result.status        = status_reg;
        result.point_covered = cov_reg;
        result.entries_used  = 5'(count_reg);
        result.total_covered = tot_reg;
        result.span_start    = first_reg;
        result.span_end      = last_reg;
    end

endmodule

>>> rtl/core/interval_set_table.sv
// top level of the interval set table
//   channel   signals                     direction
//   command   start, busy, cmd            in
//   result    done, result                out
// busy rises at the accept edge and stays high while the command runs: the walk
// reads each stored entry through the registered table read, then the copy back
// and the stats sum step through the entries in turn.
// operations that change nothing skip the walk and copy.
// done and the result show in the first cycle after busy falls; the receiver cannot stall.
// start is taken while busy is low; reset empties the table at once.
module interval_set_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ist_pkg::cmd_t   cmd,
    output logic            done,
    output ist_pkg::rsp_t   result
);

    ist_pkg::ctl_t ctl;
    ist_pkg::sts_t sts;

    // controller
    ist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // datapath
    ist_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .sts    (sts),
        .done   (done),
        .result (result)
    );

endmodule

>>> rtl/core/ist_checker.sv
// port-level checks for the interval set table
module ist_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input ist_pkg::rsp_t   result
);

    // a beat taken makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("accept did not raise busy");

    // a result lands only right after the block was busy
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without command");

    // entry count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.entries_used <= 5'(ist_pkg::MaxEntries))
        else $error("entry count over capacity");

    // an empty table reports zero coverage
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.entries_used == 5'd0 |-> result.total_covered == 64'd0)
        else $error("empty table with coverage");

endmodule

bind interval_set_table ist_checker u_ist_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> sim/tb_interval_set_table.sv
// self-checking testbench for the interval set table
module tb_interval_set_table;

    localparam int WatchdogLimit = 2000;
    localparam logic signed [63:0] SMax = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    ist_pkg::cmd_t  cmd = '0;
    logic           done;
    ist_pkg::rsp_t  result;

    // model copy of the table
    logic signed [63:0] tbl_lo[$];
    logic signed [63:0] tbl_hi[$];
    ist_pkg::rsp_t expected_rsp[$];
    int    fail_count = 0;
    int    idle_cycles = 0;
    int    burst_left = 0;

    interval_set_table u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #10 clk = ~clk;

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] x,
                                                   logic signed [63:0] a);
        logic signed [64:0] w;
        w = 65'(x) + 65'(a);
        if (w > 65'(SMax))
            return SMax;
        if (w < 65'(SMin))
            return SMin;
        return w[63:0];
    endfunction

    // apply one command to the model table and return the response beat
    function automatic ist_pkg::rsp_t apply_cmd(ist_pkg::cmd_t c);
        ist_pkg::rsp_t r;
        logic signed [63:0] ns[$];
        logic signed [63:0] ne[$];
        logic signed [63:0] ms, me, s, e, rs, re;
        logic [64:0] tot;
        bit   placed, write_back;
        rs = c.range_start;
        re = c.range_end;
        r = '0;
        write_back = 1'b0;
        placed = 1'b0;
        if (c.kind <= ist_pkg::KIND_INTERSECT && re < rs)
            r.status = ist_pkg::STATUS_ORDER;
        else if (c.kind == ist_pkg::KIND_UNION && rs != re)
        begin
            ms = rs;
            me = re;
            foreach (tbl_lo[i])
            begin
                s = tbl_lo[i];
                e = tbl_hi[i];
                if (e < rs)
                begin
                    ns.insert(ns.size(), s);
                    ne.insert(ne.size(), e);
                end
                else if (s > re)
                begin
                    if (!placed)
                    begin
                        ns.insert(ns.size(), ms);
                        ne.insert(ne.size(), me);
                        placed = 1'b1;
                    end
                    ns.insert(ns.size(), s);
                    ne.insert(ne.size(), e);
                end
                else
                begin
                    if (s < ms) ms = s;
                    if (e > me) me = e;
                end
            end
            if (!placed)
            begin
                ns.insert(ns.size(), ms);
                ne.insert(ne.size(), me);
            end
            write_back = 1'b1;
        end
        else if (c.kind == ist_pkg::KIND_SUBTRACT && rs != re)
        begin
            foreach (tbl_lo[i])
            begin
                s = tbl_lo[i];
                e = tbl_hi[i];
                if (e <= rs || s >= re)
                begin
                    ns.insert(ns.size(), s);
                    ne.insert(ne.size(), e);
                end
                else
                begin
                    if (s < rs)
                    begin
                        ns.insert(ns.size(), s);
                        ne.insert(ne.size(), rs);
                    end
                    if (e > re)
                    begin
                        ns.insert(ns.size(), re);
                        ne.insert(ne.size(), e);
                    end
                end
            end
            write_back = 1'b1;
        end
        else if (c.kind == ist_pkg::KIND_INTERSECT)
        begin
            foreach (tbl_lo[i])
            begin
                s = (tbl_lo[i] < rs) ? rs : tbl_lo[i];
                e = (tbl_hi[i] > re) ? re : tbl_hi[i];
                if (s < e)
                begin
                    ns.insert(ns.size(), s);
                    ne.insert(ne.size(), e);
                end
            end
            write_back = 1'b1;
        end
        else if (c.kind == ist_pkg::KIND_SHIFT)
        begin
            foreach (tbl_lo[i])
            begin
                s = sat_sum(tbl_lo[i], c.shift_amount);
                e = sat_sum(tbl_hi[i], c.shift_amount);
                if (s != e)
                begin
                    ns.insert(ns.size(), s);
                    ne.insert(ne.size(), e);
                end
            end
            write_back = 1'b1;
        end
        else if (c.kind == ist_pkg::KIND_POINT)
        begin
            foreach (tbl_lo[i])
                if (tbl_lo[i] <= rs && rs < tbl_hi[i])
                    r.point_covered = 1'b1;
        end
        if (write_back)
        begin
            if (ns.size() > ist_pkg::MaxEntries)
                r.status = ist_pkg::STATUS_FULL;
            else
            begin
                tbl_lo = ns;
                tbl_hi = ne;
            end
        end
        // table statistics, lengths taken as unsigned
        tot = '0;
        foreach (tbl_lo[i])
        begin
            tot = tot + {1'b0, 64'(tbl_hi[i] - tbl_lo[i])};
            if (tot[64])
                tot = {1'b0, 64'hffff_ffff_ffff_ffff};
        end
        r.entries_used = 5'(tbl_lo.size());
        r.total_covered = tot[63:0];
        if (tbl_lo.size() > 0)
        begin
            r.span_start = tbl_lo[0];
            r.span_end = tbl_hi[tbl_hi.size() - 1];
        end
        return r;
    endfunction

    // send one command beat, with bursty gaps before it
    task automatic send_cmd(logic [2:0] k, logic signed [63:0] rs,
                            logic signed [63:0] re, logic signed [63:0] amt);
        ist_pkg::cmd_t c;
        int   gap;
        c.kind = k;
        c.range_start = rs;
        c.range_end = re;
        c.shift_amount = amt;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        // wait for idle away from the rising edge; only this task raises busy
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        start <= 1'b1;
        cmd <= c;
        expected_rsp.insert(expected_rsp.size(), apply_cmd(c));
        // the beat is taken at this edge
        @(posedge clk);
        start <= 1'b0;
        cmd <= '0;
    endtask

    function automatic logic signed [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // values clustered near a base to get overlaps
    function automatic logic signed [63:0] near_val(logic signed [63:0] base);
        return base + 64'($signed($urandom_range(0, 400)) - 200);
    endfunction

    // check each response beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected response beat");
                fail_count++;
            end
            else
            begin
                ist_pkg::rsp_t x;
                x = expected_rsp.pop_front();
                if (result.status !== x.status)
                begin
                    $error("status exp %0d got %0d", x.status, result.status);
                    fail_count++;
                end
                if (result.point_covered !== x.point_covered)
                begin
                    $error("point_covered exp %0d got %0d", x.point_covered,
                           result.point_covered);
                    fail_count++;
                end
                if (result.entries_used !== x.entries_used)
                begin
                    $error("entries_used exp %0d got %0d", x.entries_used,
                           result.entries_used);
                    fail_count++;
                end
                if (result.total_covered !== x.total_covered)
                begin
                    $error("total_covered exp %0h got %0h", x.total_covered,
                           result.total_covered);
                    fail_count++;
                end
                if (result.span_start !== x.span_start)
                begin
                    $error("span_start exp %0d got %0d", x.span_start,
                           result.span_start);
                    fail_count++;
                end
                if (result.span_end !== x.span_end)
                begin
                    $error("span_end exp %0d got %0d", x.span_end, result.span_end);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted beat or response
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("tb_interval_set_table: errors");
            $finish;
        end
    end

    // extremes, every kind and the special cases
    task automatic test_directed();
        send_cmd(ist_pkg::KIND_POINT, 0, 0, 0);
        send_cmd(ist_pkg::KIND_UNION, 10, 20, 0);
        send_cmd(ist_pkg::KIND_UNION, 20, 30, 0);
        send_cmd(ist_pkg::KIND_UNION, 5, 5, 0);
        send_cmd(ist_pkg::KIND_UNION, 50, 40, 0);
        send_cmd(ist_pkg::KIND_SUBTRACT, 14, 16, 0);
        send_cmd(ist_pkg::KIND_SUBTRACT, 16, 14, 0);
        send_cmd(ist_pkg::KIND_POINT, 14, 0, 0);
        send_cmd(ist_pkg::KIND_POINT, 16, 0, 0);
        send_cmd(ist_pkg::KIND_UNION, SMin, SMin + 5, 0);
        send_cmd(ist_pkg::KIND_UNION, SMax - 5, SMax, 0);
        send_cmd(ist_pkg::KIND_POINT, SMax, 0, 0);
        send_cmd(ist_pkg::KIND_POINT, SMin, 0, 0);
        send_cmd(ist_pkg::KIND_SHIFT, 0, 0, SMax);
        send_cmd(ist_pkg::KIND_SHIFT, 0, 0, SMin);
        send_cmd(ist_pkg::KIND_UNION, SMin, SMax, 0);
        send_cmd(ist_pkg::KIND_UNION, -100, 100, 0);
        send_cmd(ist_pkg::KIND_INTERSECT, 3, 2, 0);
        send_cmd(ist_pkg::KIND_INTERSECT, -50, 50, 0);
        send_cmd(ist_pkg::KIND_INTERSECT, 7, 7, 0);
        send_cmd(3'd5, 1, 2, 3);
        send_cmd(3'd6, 1, 2, 3);
        send_cmd(3'd7, -1, -1, -1);
    endtask

    // fill the table to capacity and push past it
    task automatic test_capacity();
        for (int i = 0; i < ist_pkg::MaxEntries; i++)
            send_cmd(ist_pkg::KIND_UNION, 64'(i * 10), 64'(i * 10 + 4), 0);
        send_cmd(ist_pkg::KIND_UNION, 1000, 1002, 0);
        send_cmd(ist_pkg::KIND_SUBTRACT, 1, 2, 0);
        send_cmd(ist_pkg::KIND_SUBTRACT, 0, 1, 0);
        send_cmd(ist_pkg::KIND_UNION, 0, 200, 0);
        send_cmd(ist_pkg::KIND_INTERSECT, 0, 0, 0);
    endtask

    // random operations around a moving base value
    task automatic test_random(int count);
        logic signed [63:0] base, a, b;
        int sel;
        base = 0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 40) == 0)
                base = ($urandom_range(0, 3) == 0) ? SMax - 300 :
                       ($urandom_range(0, 2) == 0) ? SMin + 300 : rand64();
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                a = rand64();
                b = rand64();
            end
            else
            begin
                a = near_val(base);
                b = a + 64'($urandom_range(0, 60));
                if ($urandom_range(0, 15) == 0)
                    b = a - 64'($urandom_range(1, 5));
            end
            if (sel < 40)
                send_cmd(ist_pkg::KIND_UNION, a, b, rand64());
            else if (sel < 62)
                send_cmd(ist_pkg::KIND_SUBTRACT, a, b, rand64());
            else if (sel < 67)
                send_cmd(ist_pkg::KIND_INTERSECT, a - 300, b + 300, rand64());
            else if (sel < 74)
                send_cmd(ist_pkg::KIND_SHIFT, rand64(), rand64(),
                         ($urandom_range(0, 3) == 0) ? rand64() :
                         64'($signed($urandom_range(0, 100)) - 50));
            else if (sel < 97)
                send_cmd(ist_pkg::KIND_POINT, a, rand64(), rand64());
            else
                send_cmd(3'($urandom_range(5, 7)), rand64(), rand64(), rand64());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random(620);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("tb_interval_set_table: clean");
        else
            $display("tb_interval_set_table: errors");
        $finish;
    end

endmodule
